// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hcd_pkg.sv -----
`timescale 1ns / 1ps

package hcd_pkg;

    localparam int unsigned SizeWidth  = 32;
    localparam int unsigned MaxDigits  = 8;
    localparam logic [SizeWidth-1:0] MaxChunkReset = 32'h0001_0000;

    localparam logic [7:0] ChCr = 8'h0D;
    localparam logic [7:0] ChLf = 8'h0A;

    // Parser phases.
    localparam logic [3:0] PH_SIZE    = 4'd0;
    localparam logic [3:0] PH_SIZE_LF = 4'd1;
    localparam logic [3:0] PH_DATA    = 4'd2;
    localparam logic [3:0] PH_DATA_CR = 4'd3;
    localparam logic [3:0] PH_DATA_LF = 4'd4;
    localparam logic [3:0] PH_END_CR  = 4'd5;
    localparam logic [3:0] PH_END_LF  = 4'd6;
    localparam logic [3:0] PH_CLOSED  = 4'd7;

    // Result kinds.
    localparam logic [2:0] K_FRAME  = 3'd0;
    localparam logic [2:0] K_DATA   = 3'd1;
    localparam logic [2:0] K_END    = 3'd2;
    localparam logic [2:0] K_PROTO  = 3'd3;
    localparam logic [2:0] K_SIZE   = 3'd4;
    localparam logic [2:0] K_CLOSED = 3'd5;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } hcd_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
    } hcd_result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hcd_hex_t;

    function automatic hcd_hex_t hex_digit(input logic [7:0] b);
        hcd_hex_t r;
        r.is_hex = 1'b1;
        r.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.value = b[3:0];
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            // Letters a..f and A..F share the low three bits: 1..6 maps to 10..15.
            r.value = 4'(b[2:0] + 3'd1) + 4'd8;
        end
        else begin
            r.is_hex = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/hcd_in_stage.sv -----
`timescale 1ns / 1ps

module hcd_in_stage import hcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [7:0] in_byte,
    input  logic      advance,
    output hcd_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

// ----- rtl/hcd_parser.sv -----
`timescale 1ns / 1ps

module hcd_parser import hcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SizeWidth-1:0] cfg_data,
    input  hcd_item_t            item,
    input  logic                 advance,
    output hcd_result_t          result
);

    logic [SizeWidth-1:0] max_chunk_reg;
    logic [3:0]           phase_reg;
    logic [3:0]           phase_next;
    logic [SizeWidth-1:0] size_accum_reg;
    logic [SizeWidth-1:0] size_accum_next;
    logic [3:0]           digit_count_reg;
    logic [3:0]           digit_count_next;
    logic [SizeWidth-1:0] bytes_left_reg;
    logic [SizeWidth-1:0] bytes_left_next;
    hcd_hex_t             hex;
    logic [7:0]           b;

    assign b   = item.data;
    assign hex = hex_digit(b);

    always_comb
    begin
        phase_next       = phase_reg;
        size_accum_next  = size_accum_reg;
        digit_count_next = digit_count_reg;
        bytes_left_next  = bytes_left_reg;
        result.kind      = K_FRAME;
        result.out_byte  = 8'd0;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if (b == ChCr)
                begin
                    phase_next = PH_SIZE_LF;
                end
                else if (!hex.is_hex)
                begin
                    result.kind = K_PROTO;
                    phase_next  = PH_CLOSED;
                end
                else if (digit_count_reg >= 4'(MaxDigits))
                begin
                    result.kind = K_SIZE;
                    phase_next  = PH_CLOSED;
                end
                else
                begin
                    size_accum_next  = {size_accum_reg[SizeWidth-5:0], hex.value};
                    digit_count_next = digit_count_reg + 4'd1;
                end
            end
            PH_SIZE_LF:
            begin
                if (b != ChLf)
                begin
                    result.kind = K_PROTO;
                    phase_next  = PH_CLOSED;
                end
                else if (size_accum_reg > max_chunk_reg)
                begin
                    result.kind = K_SIZE;
                    phase_next  = PH_CLOSED;
                end
                else if (size_accum_reg == '0)
                begin
                    phase_next = PH_END_CR;
                end
                else
                begin
                    bytes_left_next = size_accum_reg;
                    phase_next      = PH_DATA;
                end
            end
            PH_DATA:
            begin
                result.kind     = K_DATA;
                result.out_byte = b;
                if (bytes_left_reg != '0)
                begin
                    bytes_left_next = bytes_left_reg - 1'b1;
                end
                if (bytes_left_reg <= SizeWidth'(1))
                begin
                    phase_next = PH_DATA_CR;
                end
            end
            PH_DATA_CR, PH_END_CR:
            begin
                if (b == ChCr)
                begin
                    phase_next = phase_reg + 4'd1;
                end
                else
                begin
                    result.kind = K_PROTO;
                    phase_next  = PH_CLOSED;
                end
            end
            PH_DATA_LF:
            begin
                if (b == ChLf)
                begin
                    phase_next       = PH_SIZE;
                    size_accum_next  = '0;
                    digit_count_next = 4'd0;
                end
                else
                begin
                    result.kind = K_PROTO;
                    phase_next  = PH_CLOSED;
                end
            end
            PH_END_LF:
            begin
                result.kind = (b == ChLf) ? K_END : K_PROTO;
                phase_next  = PH_CLOSED;
            end
            default:
            begin
                result.kind = K_CLOSED;
                phase_next  = PH_CLOSED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chunk_reg   <= MaxChunkReset;
            phase_reg       <= PH_SIZE;
            size_accum_reg  <= '0;
            digit_count_reg <= 4'd0;
            bytes_left_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_chunk_reg <= cfg_data;
            end
            if (advance)
            begin
                phase_reg       <= phase_next;
                size_accum_reg  <= size_accum_next;
                digit_count_reg <= digit_count_next;
                bytes_left_reg  <= bytes_left_next;
            end
        end
    end

endmodule

// ----- rtl/http_chunked_decoder.sv -----
`timescale 1ns / 1ps
// A byte accepted into the input register is parsed combinationally and moves,
// with its result, into the result register when that register is empty or
// its transaction completes. One byte per cycle is taken while out_stall is low;
// the parse state updates as a byte moves from the input to the result register.
// Reset (rst_n, asynchronous, active low) empties both registers, returns the
// parser to the size line and sets the chunk size limit to 65536.

module http_chunked_decoder import hcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SizeWidth-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           in_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           kind,
    output logic [7:0]           out_byte
);

    hcd_item_t   item;
    hcd_result_t result;
    logic        advance;
    logic        out_valid_reg;
    logic        out_valid_next;
    hcd_result_t out_reg;

    // A byte moves into the result register when that register is empty or
    // its transaction completes in this cycle.
    assign advance = item.valid && (!out_valid_reg || !out_stall);

    hcd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .advance  (advance),
        .item     (item)
    );

    hcd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item),
        .advance  (advance),
        .result   (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign out_byte  = out_reg.out_byte;

endmodule

// ----- rtl/hcd_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcd_checker import hcd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [2:0]           kind,
    input logic [7:0]           out_byte
);

    logic out_xfer;
    logic terminal;
    logic closed_reg;

    assign out_xfer = out_valid && !out_stall;
    assign terminal = kind == K_END || kind == K_PROTO || kind == K_SIZE
                      || kind == K_CLOSED;

    // Once an end or an error has been delivered, the stream stays closed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b0;
        end
        else if (out_xfer && terminal)
        begin
            closed_reg <= 1'b1;
        end
    end

    `HCD_ASSERT_NOW(a_closed_sticky, clk, rst_n, out_valid && closed_reg, kind == K_CLOSED,
        "result after end or error is not closed")
    `HCD_ASSERT_NOW(a_byte_zero, clk, rst_n, out_valid && kind != K_DATA, out_byte == 8'd0,
        "out_byte nonzero outside a payload transaction")
    `HCD_ASSERT_NOW(a_no_stall_empty, clk, rst_n, !out_valid, !in_stall,
        "input stalled while the result register is empty")
    `HCD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(kind) && $stable(out_byte),
        "stalled result changed")

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte)
);

// ----- dv/http_chunked_decoder_test.sv -----
`timescale 1ns / 1ps

module http_chunked_decoder_test;
    import hcd_pkg::*;

    localparam int QuietLimit = 2000;

    // Ways the stream is brought to its one and only close.
    typedef enum int {
        END_CLEAN,
        END_EMPTY_LINE,
        END_NINTH_DIGIT,
        END_BAD_DIGIT,
        END_OVER_LIMIT,
        END_NO_SIZE_LF,
        END_NO_DATA_CR,
        END_NO_DATA_LF,
        END_NO_TRAILER_CR,
        END_NO_TRAILER_LF
    } stream_end_e;

    class chunk_board;
        logic [3:0]  parse_phase;
        logic [31:0] size_value;
        logic [3:0]  size_digits;
        logic [31:0] payload_left;
        logic [31:0] size_limit;
        hcd_result_t outcomes_due[$];
        int          mismatches;

        function new();
            parse_phase  = PH_SIZE;
            size_value   = '0;
            size_digits  = '0;
            payload_left = '0;
            size_limit   = MaxChunkReset;
            mismatches   = 0;
        endfunction

        static function int hex_value(logic [7:0] b);
            if (b >= 8'h30 && b <= 8'h39)
                return int'(b) - 'h30;
            if (b >= 8'h61 && b <= 8'h66)
                return int'(b) - 'h61 + 10;
            if (b >= 8'h41 && b <= 8'h46)
                return int'(b) - 'h41 + 10;
            return -1;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        // Advances the parse state by one accepted byte and queues its outcome.
        function void note_byte(logic [7:0] b);
            hcd_result_t r;
            int v;
            r.kind     = K_FRAME;
            r.out_byte = 8'h00;
            case (parse_phase)
                PH_SIZE:
                begin
                    v = hex_value(b);
                    if (b == ChCr)
                        parse_phase = PH_SIZE_LF;
                    else if (v < 0)
                    begin
                        r.kind      = K_PROTO;
                        parse_phase = PH_CLOSED;
                    end
                    else if (size_digits >= MaxDigits)
                    begin
                        r.kind      = K_SIZE;
                        parse_phase = PH_CLOSED;
                    end
                    else
                    begin
                        size_value  = {size_value[27:0], 4'(v)};
                        size_digits = size_digits + 4'd1;
                    end
                end
                PH_SIZE_LF:
                begin
                    if (b != ChLf)
                    begin
                        r.kind      = K_PROTO;
                        parse_phase = PH_CLOSED;
                    end
                    else if (size_value > size_limit)
                    begin
                        r.kind      = K_SIZE;
                        parse_phase = PH_CLOSED;
                    end
                    else if (size_value == 0)
                        parse_phase = PH_END_CR;
                    else
                    begin
                        payload_left = size_value;
                        parse_phase  = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    r.kind     = K_DATA;
                    r.out_byte = b;
                    if (payload_left > 0)
                        payload_left = payload_left - 1;
                    if (payload_left == 0)
                        parse_phase = PH_DATA_CR;
                end
                PH_DATA_CR, PH_END_CR:
                begin
                    if (b == ChCr)
                        parse_phase = parse_phase + 4'd1;
                    else
                    begin
                        r.kind      = K_PROTO;
                        parse_phase = PH_CLOSED;
                    end
                end
                PH_DATA_LF:
                begin
                    if (b == ChLf)
                    begin
                        parse_phase = PH_SIZE;
                        size_value  = '0;
                        size_digits = '0;
                    end
                    else
                    begin
                        r.kind      = K_PROTO;
                        parse_phase = PH_CLOSED;
                    end
                end
                PH_END_LF:
                begin
                    r.kind      = (b == ChLf) ? K_END : K_PROTO;
                    parse_phase = PH_CLOSED;
                end
                default:
                begin
                    r.kind      = K_CLOSED;
                    parse_phase = PH_CLOSED;
                end
            endcase
            outcomes_due.push_back(r);
        endfunction

        task report(string what);
            $display("%0t ns mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_outcome(logic [2:0] got_kind, logic [7:0] got_byte);
            hcd_result_t want;
            if (outcomes_due.size() == 0)
            begin
                report($sformatf("result kind %0d byte %02h with nothing expected",
                                 got_kind, got_byte));
                return;
            end
            want = outcomes_due[0];
            outcomes_due.delete(0);
            if (got_kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got_kind, want.kind));
            if (got_byte !== want.out_byte)
                report($sformatf("out_byte %02h, expected %02h", got_byte, want.out_byte));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [7:0]  out_byte;

    chunk_board  board = new();
    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;

    http_chunked_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall = ($urandom_range(99) < stall_pct);
    end

    // Scoreboard feed and a watchdog on cycles where no transaction moves.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_byte(in_byte);
        if (rst_n && out_valid && !out_stall)
            board.check_outcome(kind, out_byte);
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("http_chunked_decoder_test: done, errors");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            in_byte  = 8'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_crlf();
        send_byte(ChCr);
        send_byte(ChLf);
    endtask

    function automatic int hex_width(logic [31:0] v);
        int n;
        n = 1;
        while (n < 8 && (v >> (4 * n)) != 0)
            n++;
        return n;
    endfunction

    // Digits above the eighth are leading zeros.
    task automatic send_size_digits(input logic [31:0] value, input int width);
        logic [3:0] nib;
        logic [7:0] ch;
        for (int i = width - 1; i >= 0; i--)
        begin
            nib = (i < 8) ? value[i * 4 +: 4] : 4'h0;
            if (nib < 10)
                ch = 8'h30 + 8'(nib);
            else
                ch = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
            send_byte(ch);
        end
    endtask

    task automatic send_chunk(input int unsigned size);
        int width;
        width = hex_width(size);
        if ($urandom_range(3) == 0)
            width = $urandom_range(8, width);
        send_size_digits(size, width);
        send_crlf();
        repeat (size) send_byte(8'($urandom_range(255)));
        send_crlf();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        wait_drained();
        @(negedge clk);
        cfg_we           = 1'b1;
        cfg_data         = v;
        board.size_limit = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic int unsigned pick_size();
        int unsigned cap;
        int unsigned short_cap;
        cap       = (board.size_limit < 48) ? board.size_limit : 48;
        short_cap = (cap < 12) ? cap : 12;
        if ($urandom_range(7) == 0)
            return $urandom_range(cap, 1);
        return $urandom_range(short_cap, 1);
    endfunction

    task automatic run_phase(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target)
        begin
            send_chunk(pick_size());
            // Now and then hold the sender until the output side has caught up.
            if ($urandom_range(15) == 0)
                wait_drained();
        end
    endtask

    function automatic logic [7:0] byte_except(input logic [7:0] avoid);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (chunk_board::hex_value(b) >= 0 || b == ChCr);
        return b;
    endfunction

    // Size line for one byte of payload, followed by that byte.
    task automatic send_chunk_head_one();
        send_size_digits(32'd1, $urandom_range(8, 1));
        send_crlf();
        send_byte(8'($urandom));
    endtask

    // The decoder closes for good after an end or an error, so the run ends
    // with exactly one such event, picked at random.
    task automatic close_stream();
        stream_end_e ending;
        logic [31:0] v;
        ending = stream_end_e'($urandom_range(END_NO_TRAILER_LF, END_CLEAN));
        write_limit((ending == END_NO_DATA_CR || ending == END_NO_DATA_LF) ? 32'd1 : 32'd0);
        case (ending)
            END_CLEAN:
            begin
                send_size_digits(32'd0, $urandom_range(8, 1));
                send_crlf();
                send_crlf();
            end
            END_EMPTY_LINE:
            begin
                send_crlf();
                send_crlf();
            end
            END_NINTH_DIGIT:
                send_size_digits($urandom, 9);
            END_BAD_DIGIT:
            begin
                send_size_digits(32'd0, $urandom_range(2));
                send_byte(non_hex_byte());
            end
            END_OVER_LIMIT:
            begin
                v = $urandom_range(32'hFFFF_FFFF, 1);
                send_size_digits(v, $urandom_range(8, hex_width(v)));
                send_crlf();
            end
            END_NO_SIZE_LF:
            begin
                send_size_digits(32'd0, 1);
                send_byte(ChCr);
                send_byte(byte_except(ChLf));
            end
            END_NO_DATA_CR:
            begin
                send_chunk_head_one();
                send_byte(byte_except(ChCr));
            end
            END_NO_DATA_LF:
            begin
                send_chunk_head_one();
                send_byte(ChCr);
                send_byte(byte_except(ChLf));
            end
            END_NO_TRAILER_CR:
            begin
                send_size_digits(32'd0, 1);
                send_crlf();
                send_byte(byte_except(ChCr));
            end
            END_NO_TRAILER_LF:
            begin
                send_size_digits(32'd0, 1);
                send_crlf();
                send_byte(ChCr);
                send_byte(byte_except(ChLf));
            end
            default:
                send_crlf();
        endcase
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (20) send_byte(8'($urandom));
    endtask

    initial
    begin
        int unsigned tight_limit;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_byte   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: single-digit and full-width size lines, payload extremes,
        // and a CR passed through as payload.
        send_size_digits(32'd1, 1);
        send_crlf();
        send_byte(8'h00);
        send_crlf();
        send_size_digits(32'd2, 8);
        send_crlf();
        send_byte(8'hFF);
        send_byte(ChCr);
        send_crlf();

        run_phase(230);

        write_limit(32'hFFFF_FFFF);
        sender_idle_pct = 82;
        stall_pct       = 0;
        run_phase(230);

        // A chunk exactly at the limit must still pass.
        tight_limit = $urandom_range(12, 1);
        write_limit(tight_limit);
        sender_idle_pct = 0;
        stall_pct       = 82;
        send_chunk(tight_limit);
        run_phase(230);

        write_limit($urandom_range(32'h0010_0000, 48));
        sender_idle_pct = 20;
        stall_pct       = 20;
        run_phase(230);

        close_stream();
        wait_drained();
        repeat (8) @(posedge clk);
        if (board.mismatches == 0)
            $display("http_chunked_decoder_test: done, clean");
        else
            $display("http_chunked_decoder_test: done, errors");
        $finish;
    end

endmodule
